// ===== src/avcc_nal_pkg.sv =====
`default_nettype none

package avcc_nal_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int LENGTH_BITS  = 16;
    localparam int BYTE_BITS    = 8;

    // Low five bits of the sixth byte carry the SPS count
    localparam logic [BYTE_BITS-1:0] SPS_COUNT_MASK = 8'h1f;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_HEADER    = 3'd1;
    localparam logic [2:0] PH_SPS_COUNT = 3'd2;
    localparam logic [2:0] PH_LEN_HI    = 3'd3;
    localparam logic [2:0] PH_LEN_LO    = 3'd4;
    localparam logic [2:0] PH_DATA      = 3'd5;
    localparam logic [2:0] PH_PPS_COUNT = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_NORMAL = 2'd1;
    localparam logic [1:0] END_TRUNC  = 2'd2;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] end_code;
    } move_t;

    // Pick what follows once the byte at pos has been consumed.
    function automatic move_t move_on(
        input logic [LENGTH_BITS-1:0] pos,
        input logic [BYTE_BITS-1:0]   units,
        input logic                   kind,
        input logic [LENGTH_BITS-1:0] total
    );
        move_t                  mv;
        logic [LENGTH_BITS+1:0] nxt;
        logic [LENGTH_BITS+1:0] tot;
        nxt = (LENGTH_BITS+2)'(pos) + (LENGTH_BITS+2)'(1);
        tot = (LENGTH_BITS+2)'(total);
        mv.phase    = PH_DONE;
        mv.end_code = END_NORMAL;
        if (units != '0)
        begin
            if (nxt + (LENGTH_BITS+2)'(1) >= tot)
            begin
                mv.end_code = END_TRUNC;
            end
            else
            begin
                mv.phase    = PH_LEN_HI;
                mv.end_code = END_NONE;
            end
        end
        else if (!kind)
        begin
            if (nxt >= tot)
            begin
                mv.end_code = END_TRUNC;
            end
            else
            begin
                mv.phase    = PH_PPS_COUNT;
                mv.end_code = END_NONE;
            end
        end
        return mv;
    endfunction

endpackage

`default_nettype wire

// ===== src/avcc_record_nal_locator_top.sv =====
// A result is registered: an accepted byte lands in the input register, and its result
// loads into the result register when that byte advances out of the input register.
// Throughput: one byte per cycle; the per-byte work is one counter update and a
// compare between the two registers. Input stalls only while a result waits.
// Reset (rst_n low, asynchronous): parser idle, counters cleared, no result pending.
`default_nettype none

module avcc_record_nal_locator_top
    import avcc_nal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // data_byte[7:0], record_length[23:8]
    input  wire logic        s_axis_tuser,  // first_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // unit_offset[15:0], unit_size[31:16]
    output logic [2:0]       m_axis_tuser,  // unit_found, unit_kind, truncated
    output logic             m_axis_tlast   // parse_done
);

    localparam int LB = LENGTH_BITS;

    logic                 in_valid_reg;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_first_reg;
    logic [LB-1:0]        in_len_reg;
    logic                 advance;

    logic [2:0]           phase_reg, phase_next;
    logic [LB-1:0]        pos_reg, pos_next;
    logic [LB-1:0]        total_reg, total_next;
    logic [BYTE_BITS-1:0] units_reg, units_next;
    logic [BYTE_BITS-1:0] lenhi_reg, lenhi_next;
    logic [LB-1:0]        skip_reg, skip_next;
    logic                 kind_reg, kind_next;

    logic                 found;
    logic                 f_kind;
    logic [LB-1:0]        f_off;
    logic [LB-1:0]        f_size;
    logic [1:0]           end_code;
    move_t                mv;

    logic [LB-1:0]        pos_inc;
    logic [LB-1:0]        size_w;
    logic [LB:0]          start_w;
    logic [LB:0]          room_w;
    logic [BYTE_BITS-1:0] units_dec;
    logic [LB-1:0]        skip_dec;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic                 out_kind_reg;
    logic [LB-1:0]        out_off_reg;
    logic [LB-1:0]        out_size_reg;
    logic                 out_done_reg;
    logic                 out_trunc_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata[BYTE_BITS-1:0];
            in_len_reg   <= s_axis_tdata[BYTE_BITS+LB-1:BYTE_BITS];
            in_first_reg <= s_axis_tuser;
        end
    end

    assign pos_inc   = pos_reg + LB'(1);
    assign size_w    = {lenhi_reg, in_byte_reg};
    assign start_w   = (LB+1)'(pos_inc) + (LB+1)'(1);
    assign room_w    = (LB+1)'(total_reg) - start_w;
    assign units_dec = units_reg - BYTE_BITS'(1);
    assign skip_dec  = skip_reg - LB'(1);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        units_next = units_reg;
        lenhi_next = lenhi_reg;
        skip_next  = skip_reg;
        kind_next  = kind_reg;
        found      = 1'b0;
        f_kind     = 1'b0;
        f_off      = '0;
        f_size     = '0;
        end_code   = END_NONE;
        mv         = '{phase: PH_DONE, end_code: END_NONE};

        if (in_first_reg)
        begin
            // restart on any first byte
            total_next = in_len_reg;
            pos_next   = '0;
            units_next = '0;
            lenhi_next = '0;
            skip_next  = '0;
            kind_next  = 1'b0;
            phase_next = PH_HEADER;
            if (in_len_reg <= LB'(HEADER_BYTES))
            begin
                phase_next = PH_DONE;
                end_code   = END_TRUNC;
            end
            else if (HEADER_BYTES <= 1)
            begin
                phase_next = PH_SPS_COUNT;
            end
        end
        else if (phase_reg != PH_IDLE && phase_reg != PH_DONE)
        begin
            pos_next = pos_inc;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if ((LB+1)'(pos_inc) + (LB+1)'(1) >= (LB+1)'(HEADER_BYTES))
                    begin
                        phase_next = PH_SPS_COUNT;
                    end
                end
                PH_SPS_COUNT:
                begin
                    units_next = in_byte_reg & SPS_COUNT_MASK;
                    kind_next  = 1'b0;
                    mv         = move_on(pos_inc, in_byte_reg & SPS_COUNT_MASK, 1'b0,
                                         total_reg);
                    phase_next = mv.phase;
                    end_code   = mv.end_code;
                end
                PH_PPS_COUNT:
                begin
                    units_next = in_byte_reg;
                    kind_next  = 1'b1;
                    mv         = move_on(pos_inc, in_byte_reg, 1'b1, total_reg);
                    phase_next = mv.phase;
                    end_code   = mv.end_code;
                end
                PH_LEN_HI:
                begin
                    lenhi_next = in_byte_reg;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    units_next = units_dec;
                    if ((LB+1)'(size_w) > room_w)
                    begin
                        // unit overruns the record: drop the rest of this list
                        units_next = '0;
                        mv         = move_on(pos_inc, '0, kind_reg, total_reg);
                        phase_next = mv.phase;
                        end_code   = mv.end_code;
                    end
                    else
                    begin
                        found  = 1'b1;
                        f_kind = kind_reg;
                        f_off  = start_w[LB-1:0];
                        f_size = size_w;
                        if (size_w != '0)
                        begin
                            skip_next  = size_w;
                            phase_next = PH_DATA;
                            if (kind_reg && units_dec == '0)
                            begin
                                phase_next = PH_DONE;
                                end_code   = END_NORMAL;
                            end
                        end
                        else
                        begin
                            mv         = move_on(pos_inc, units_dec, kind_reg, total_reg);
                            phase_next = mv.phase;
                            end_code   = mv.end_code;
                        end
                    end
                end
                PH_DATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        mv         = move_on(pos_inc, units_reg, kind_reg, total_reg);
                        phase_next = mv.phase;
                        end_code   = mv.end_code;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            total_reg     <= '0;
            units_reg     <= '0;
            lenhi_reg     <= '0;
            skip_reg      <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                total_reg <= total_next;
                units_reg <= units_next;
                lenhi_reg <= lenhi_next;
                skip_reg  <= skip_next;
                kind_reg  <= kind_next;
                if (found || end_code != END_NONE)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (found || end_code != END_NONE))
        begin
            out_found_reg <= found;
            out_kind_reg  <= f_kind;
            out_off_reg   <= f_off;
            out_size_reg  <= f_size;
            out_done_reg  <= (end_code != END_NONE);
            out_trunc_reg <= (end_code == END_TRUNC);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_size_reg, out_off_reg};
    assign m_axis_tuser  = {out_trunc_reg, out_kind_reg, out_found_reg};
    assign m_axis_tlast  = out_done_reg;

    a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tlast)
        else $error("truncated result without parse_done");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("result without a unit carries nonzero unit fields");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !(advance && in_first_reg)) |=> (phase_reg == PH_DONE))
        else $error("parser left done without a first byte");

    a_found_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && found) |-> ((LB+1)'(f_off) + (LB+1)'(f_size) <= (LB+1)'(total_reg)))
        else $error("reported unit extends past the record");

endmodule

`default_nettype wire
